// ===== sv/steady_state_genetic_step_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef STEADY_STATE_GENETIC_STEP_CORE_DEFINES_SVH
`define STEADY_STATE_GENETIC_STEP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SSGS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SSGS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssgs_pkg.sv =====
// Package: sizes, tables, command/status types for the genetic step core.
`timescale 1ns / 1ps
package ssgs_pkg;

  localparam int POP_SIZE        = 32;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int IDX_W  = (POP_SIZE > 2) ? $clog2(POP_SIZE) : 1;
  localparam int TAB_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int SLOT_W = 5;
  localparam int DATA_W = 16;
  localparam int OFS_W  = 13;
  localparam int ENT_W  = 3 * DATA_W;
  localparam int MANT_W = 17;

  localparam logic signed [OFS_W-1:0] OFS_RESET = 13'sd123;
  localparam logic signed [17:0]      LOG2E_Q16 = 18'sd94548;

  localparam longint LN2_Q30 = 64'd744261118;
  localparam longint ONE_Q30 = 64'd1073741824;

  typedef logic [IDX_W-1:0]  mod_tab_t [2**SLOT_W];
  typedef logic [MANT_W-1:0] exp_tab_t [EXP_TABLE_DEPTH];

  // slot field reduced modulo the population size
  function automatic mod_tab_t build_mod_tab();
    mod_tab_t tab;
    for (int v = 0; v < 2**SLOT_W; v++) begin
      tab[v] = IDX_W'(v % POP_SIZE);
    end
    return tab;
  endfunction

  // floor quotient of a non-negative value by a small positive count, shift and subtract
  function automatic longint div_small(input longint num, input int den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int bit_pos = 62; bit_pos >= 0; bit_pos--) begin
      rem = (rem <<< 1) | ((num >>> bit_pos) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= longint'(den)) begin
        rem = rem - longint'(den);
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // 2^(-i/DEPTH) in Q16 from the exp(-z) series through the z^16 term, z = i*ln2/DEPTH
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    longint z;
    longint term;
    longint sum;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      z    = (longint'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
      term = ONE_Q30;
      sum  = ONE_Q30;
      for (int k = 1; k <= 16; k++) begin
        term = div_small((term * z) >>> 30, k);
        if ((k & 1) != 0) sum = sum - term;
        else sum = sum + term;
      end
      tab[i] = MANT_W'((sum + 64'd8192) >>> 14);
    end
    return tab;
  endfunction

  localparam mod_tab_t MOD_TAB = build_mod_tab();
  localparam exp_tab_t EXP_TAB = build_exp_tab();

  function automatic logic signed [DATA_W-1:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    else if (v < -32'sd32768) return 16'sh8000;
    else return v[DATA_W-1:0];
  endfunction

  typedef enum logic [4:0] {
    DP_NOP, DP_CAPTURE, DP_LOAD, DP_BAD, DP_RD_A, DP_RD_B, DP_RD_C, DP_SCAN,
    DP_CHOOSE, DP_SQX, DP_SQY, DP_SUM, DP_LOG, DP_EXP, DP_XY, DP_MULG, DP_FIN,
    DP_WRITE
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_LOAD, ST_BAD, ST_RD_A, ST_RD_B, ST_RD_C, ST_SCAN,
    ST_CHOOSE, ST_SQX, ST_SQY, ST_SUM, ST_LOG, ST_EXP, ST_XY, ST_MULG, ST_FIN,
    ST_WRITE, ST_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic bad;
    logic scan_done;
  } status_t;

endpackage

// ===== sv/steady_state_genetic_step_core.sv =====
// Top level of the steady-state genetic step core.
//
//  channel  handshake         payload
//  input    start / busy      op, slot, gene_x, gene_y, pick_a, pick_b, pick_c
//  result   done (1 cycle)    written_slot, child_x, child_y, child_fitness,
//                             best_report, bad_picks
//  config   cfg_we            cfg_wdata (report_offset)
//
// Load and evolve both run the eight-step fitness sequence before the write; evolve
// first reads the three picks and runs the one-entry-per-cycle best scan over the
// population RAM; bad picks go straight to done. busy is high until the done cycle ends.
// Synchronous reset clears the controller and sets report_offset to its default;
// the population is undefined until loaded. Results cannot be stalled.
`timescale 1ns / 1ps
module steady_state_genetic_step_core import ssgs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     op,
  input  logic [SLOT_W-1:0]        slot,
  input  logic signed [DATA_W-1:0] gene_x,
  input  logic signed [DATA_W-1:0] gene_y,
  input  logic [SLOT_W-1:0]        pick_a,
  input  logic [SLOT_W-1:0]        pick_b,
  input  logic [SLOT_W-1:0]        pick_c,
  input  logic                     cfg_we,
  input  logic signed [OFS_W-1:0]  cfg_wdata,
  output logic                     done,
  output logic [SLOT_W-1:0]        written_slot,
  output logic signed [DATA_W-1:0] child_x,
  output logic signed [DATA_W-1:0] child_y,
  output logic signed [DATA_W-1:0] child_fitness,
  output logic signed [DATA_W-1:0] best_report,
  output logic                     bad_picks
);

  cmd_t    cmd;
  status_t stat;

  ssgs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ssgs_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .slot          (slot),
    .gene_x        (gene_x),
    .gene_y        (gene_y),
    .pick_a        (pick_a),
    .pick_b        (pick_b),
    .pick_c        (pick_c),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .written_slot  (written_slot),
    .child_x       (child_x),
    .child_y       (child_y),
    .child_fitness (child_fitness),
    .best_report   (best_report),
    .bad_picks     (bad_picks)
  );

endmodule

// ===== sv/ssgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ssgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ssgs_datapath.sv =====
// Datapath: population RAM, best scan, tournament, fitness pipeline, results.
`timescale 1ns / 1ps
module ssgs_datapath import ssgs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  output status_t                  stat,
  input  logic                     op,
  input  logic [SLOT_W-1:0]        slot,
  input  logic signed [DATA_W-1:0] gene_x,
  input  logic signed [DATA_W-1:0] gene_y,
  input  logic [SLOT_W-1:0]        pick_a,
  input  logic [SLOT_W-1:0]        pick_b,
  input  logic [SLOT_W-1:0]        pick_c,
  input  logic                     cfg_we,
  input  logic signed [OFS_W-1:0]  cfg_wdata,
  output logic [SLOT_W-1:0]        written_slot,
  output logic signed [DATA_W-1:0] child_x,
  output logic signed [DATA_W-1:0] child_y,
  output logic signed [DATA_W-1:0] child_fitness,
  output logic signed [DATA_W-1:0] best_report,
  output logic                     bad_picks
);

  localparam int E_W  = 34;
  localparam int MT_W = E_W + 18;
  localparam int T_W  = MT_W - 24;
  localparam int N_W  = T_W - 16;
  localparam int G_W  = MANT_W + 1;
  localparam int Q_W  = 2 * DATA_W + G_W + 1;
  localparam int P_W  = Q_W + 4;
  localparam int F_W  = P_W - 28;

  logic signed [OFS_W-1:0]  offset;
  logic                     op_q;
  logic [IDX_W-1:0]         slot_q, a_q, b_q, c_q, tgt;
  logic signed [DATA_W-1:0] gx_q, gy_q, fx, fy, best, cf;
  logic [ENT_W-1:0]         ent_a, ent_b, ent_c;
  logic [IDX_W:0]           scan_cnt;
  logic signed [31:0]       sqx, sqy, xy;
  logic signed [E_W-1:0]    e;
  logic signed [MT_W-1:0]   mt;
  logic [G_W-1:0]           g;
  logic signed [Q_W-1:0]    q;

  logic [ENT_W-1:0]         rdata;
  logic [IDX_W-1:0]         raddr;

  // entry layout: {x, y, fitness}
  logic signed [DATA_W-1:0] fa, fb, fc, rfit;
  assign fa   = ent_a[DATA_W-1:0];
  assign fb   = ent_b[DATA_W-1:0];
  assign fc   = ent_c[DATA_W-1:0];
  assign rfit = rdata[DATA_W-1:0];

  assign stat.is_load   = !op_q;
  assign stat.bad       = (a_q == b_q) || (a_q == c_q) || (b_q == c_q);
  assign stat.scan_done = (scan_cnt == (IDX_W+1)'(POP_SIZE));

  always_comb begin
    case (cmd.op)
      DP_RD_A: raddr = a_q;
      DP_RD_B: raddr = b_q;
      DP_RD_C: raddr = c_q;
      default: raddr = scan_cnt[IDX_W-1:0];
    endcase
  end

  ssgs_ram #(.WIDTH(ENT_W), .DEPTH(POP_SIZE)) u_pop (
    .clk   (clk),
    .we    (cmd.op == DP_WRITE),
    .waddr (tgt),
    .wdata ({fx, fy, cf}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // tournament: lowest fitness loses, on a tie the earlier pick loses
  logic                     lose_b, lose_c;
  logic signed [DATA_W-1:0] f_cur;
  logic [IDX_W-1:0]         lose;
  logic [ENT_W-1:0]         par1, par2;
  logic signed [DATA_W:0]   sum_x, sum_y, best_sum;

  always_comb begin
    lose_b = fb < fa;
    f_cur  = lose_b ? fb : fa;
    lose_c = fc < f_cur;
    if (lose_c) begin
      lose = c_q; par1 = ent_a; par2 = ent_b;
    end else if (lose_b) begin
      lose = b_q; par1 = ent_a; par2 = ent_c;
    end else begin
      lose = a_q; par1 = ent_b; par2 = ent_c;
    end
    sum_y = $signed({par1[2*DATA_W-1], par1[2*DATA_W-1:DATA_W]})
          + $signed({par2[2*DATA_W-1], par2[2*DATA_W-1:DATA_W]});
    sum_x = $signed({par1[ENT_W-1], par1[ENT_W-1:2*DATA_W]})
          + $signed({par2[ENT_W-1], par2[ENT_W-1:2*DATA_W]});
    best_sum = $signed({best[DATA_W-1], best}) + (DATA_W+1)'(offset);
  end

  // exponent: integer part as a shift, fraction through the table
  logic signed [T_W-1:0]   t;
  logic signed [N_W-1:0]   n;
  logic [TAB_W-1:0]        tidx;
  logic [MANT_W-1:0]       mant;
  logic [G_W-1:0]          g_raw;

  always_comb begin
    t    = mt[MT_W-1:24];
    n    = t[T_W-1:16];
    tidx = t[15 -: TAB_W];
    mant = EXP_TAB[tidx];
    if (n[N_W-1]) begin
      g_raw = {mant, 1'b0};
    end else if (n > $signed(N_W'(16))) begin
      g_raw = '0;
    end else begin
      g_raw = {1'b0, mant} >> n[4:0];
    end
  end

  logic signed [P_W-1:0] p7;
  logic signed [F_W-1:0] fin;
  always_comb begin
    p7  = (P_W'(q) <<< 3) - P_W'(q) + (P_W'(1) <<< 27);
    fin = F_W'(p7 >>> 28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= OFS_RESET;
    end else if (cfg_we) begin
      offset <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        op_q     <= op;
        slot_q   <= MOD_TAB[slot];
        a_q      <= MOD_TAB[pick_a];
        b_q      <= MOD_TAB[pick_b];
        c_q      <= MOD_TAB[pick_c];
        gx_q     <= gene_x;
        gy_q     <= gene_y;
        scan_cnt <= '0;
      end
      DP_LOAD: begin
        fx          <= gx_q;
        fy          <= gy_q;
        tgt         <= slot_q;
        best_report <= '0;
      end
      DP_BAD: begin
        written_slot  <= '0;
        child_x       <= '0;
        child_y       <= '0;
        child_fitness <= '0;
        best_report   <= '0;
        bad_picks     <= 1'b1;
      end
      DP_RD_B: ent_a <= rdata;
      DP_RD_C: ent_b <= rdata;
      DP_SCAN: begin
        // read data arrives the cycle after its scan address
        if (scan_cnt == '0) begin
          ent_c <= rdata;
        end else if (scan_cnt == (IDX_W+1)'(1)) begin
          best <= rfit;
        end else if (rfit > best) begin
          best <= rfit;
        end
        if (!stat.scan_done) begin
          scan_cnt <= scan_cnt + (IDX_W+1)'(1);
        end
      end
      DP_CHOOSE: begin
        fx          <= sum_y[DATA_W:1];
        fy          <= sum_x[DATA_W:1];
        tgt         <= lose;
        best_report <= sat16(32'(best_sum));
      end
      DP_SQX:  sqx <= fx * fx;
      DP_SQY:  sqy <= fy * fy;
      DP_SUM:  e   <= E_W'(sqx) + E_W'(sqy) + (E_W'(fx) <<< 12);
      DP_LOG:  mt  <= MT_W'(e * LOG2E_Q16);
      DP_EXP:  g   <= (g_raw < G_W'(16)) ? '0 : g_raw;
      DP_XY:   xy  <= fx * fy;
      DP_MULG: q   <= Q_W'(xy * $signed({1'b0, g}));
      DP_FIN:  cf  <= sat16(32'(fin));
      DP_WRITE: begin
        written_slot  <= SLOT_W'(tgt);
        child_x       <= fx;
        child_y       <= fy;
        child_fitness <= cf;
        bad_picks     <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/ssgs_ctrl.sv =====
// Controller: sequences one transaction through the datapath.
`timescale 1ns / 1ps
module ssgs_ctrl import ssgs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t stat,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:   state_next = start ? ST_DECODE : ST_IDLE;
      ST_DECODE: begin
        if (stat.is_load) state_next = ST_LOAD;
        else if (stat.bad) state_next = ST_BAD;
        else state_next = ST_RD_A;
      end
      ST_LOAD:   state_next = ST_SQX;
      ST_BAD:    state_next = ST_DONE;
      ST_RD_A:   state_next = ST_RD_B;
      ST_RD_B:   state_next = ST_RD_C;
      ST_RD_C:   state_next = ST_SCAN;
      ST_SCAN:   state_next = stat.scan_done ? ST_CHOOSE : ST_SCAN;
      ST_CHOOSE: state_next = ST_SQX;
      ST_SQX:    state_next = ST_SQY;
      ST_SQY:    state_next = ST_SUM;
      ST_SUM:    state_next = ST_LOG;
      ST_LOG:    state_next = ST_EXP;
      ST_EXP:    state_next = ST_XY;
      ST_XY:     state_next = ST_MULG;
      ST_MULG:   state_next = ST_FIN;
      ST_FIN:    state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    case (state)
      ST_IDLE:   cmd.op = start ? DP_CAPTURE : DP_NOP;
      ST_LOAD:   cmd.op = DP_LOAD;
      ST_BAD:    cmd.op = DP_BAD;
      ST_RD_A:   cmd.op = DP_RD_A;
      ST_RD_B:   cmd.op = DP_RD_B;
      ST_RD_C:   cmd.op = DP_RD_C;
      ST_SCAN:   cmd.op = DP_SCAN;
      ST_CHOOSE: cmd.op = DP_CHOOSE;
      ST_SQX:    cmd.op = DP_SQX;
      ST_SQY:    cmd.op = DP_SQY;
      ST_SUM:    cmd.op = DP_SUM;
      ST_LOG:    cmd.op = DP_LOG;
      ST_EXP:    cmd.op = DP_EXP;
      ST_XY:     cmd.op = DP_XY;
      ST_MULG:   cmd.op = DP_MULG;
      ST_FIN:    cmd.op = DP_FIN;
      ST_WRITE:  cmd.op = DP_WRITE;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

// ===== sv/ssgs_checker.sv =====
// Port-level checker for the genetic step core, bound to the top level.
`timescale 1ns / 1ps
`include "steady_state_genetic_step_core_defines.svh"
module ssgs_checker import ssgs_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [SLOT_W-1:0]        written_slot,
  input logic signed [DATA_W-1:0] child_x,
  input logic signed [DATA_W-1:0] child_fitness,
  input logic                     bad_picks
);

  `SSGS_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction did not raise busy")
  `SSGS_ASSERT_IMP(a_done_in_busy, clk, rst, done, busy, "result strobe outside a transaction")
  `SSGS_ASSERT_NXT(a_done_single, clk, rst, done, !done && !busy, "result strobe longer than one cycle")
  `SSGS_ASSERT_IMP(a_bad_zero, clk, rst, done && bad_picks, written_slot == '0 && child_x == '0 && child_fitness == '0, "bad picks result carries data")

endmodule

bind steady_state_genetic_step_core ssgs_checker u_ssgs_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .written_slot  (written_slot),
  .child_x       (child_x),
  .child_fitness (child_fitness),
  .bad_picks     (bad_picks)
);
